>>> src/cst_pkg.sv
package cst_pkg;

  // Action codes carried by an input item.
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_PRESET = 2'd2;
  localparam logic [1:0] ACT_SPARE  = 2'd3;

  // Seek modes.
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_RUN     = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_DURATION = 2'd0;
  localparam logic [1:0] REG_SLOPE    = 2'd1;
  localparam logic [1:0] REG_ACCEL    = 2'd2;
  localparam logic [1:0] REG_HOLD     = 2'd3;

  // Unity in Q1.16 normalised time.
  localparam logic [16:0] T_ONE = 17'd65536;
  localparam logic [30:0] DURATION_RESET = 31'd65536;

  localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
  localparam logic signed [35:0] W_MAX36 = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] W_MIN36 = 36'shF_8000_0000;
  localparam logic [47:0] MAG_MAX = 48'h0000_7FFF_FFFF;
  localparam logic [47:0] MAG_MIN = 48'h0000_8000_0000;

  // Sign-extend a word to the width used for short sums.
  function automatic logic signed [35:0] ext36(input logic signed [31:0] v);
    return {{4{v[31]}}, v};
  endfunction

  // Saturate a short sum to the word range.
  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    if (v > W_MAX36) begin
      return W_MAX;
    end else if (v < W_MIN36) begin
      return W_MIN;
    end
    return v[31:0];
  endfunction

  // Magnitude of a word; the most negative word gives 2^31.
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    if (v[31]) begin
      return 32'(~v + 32'sd1);
    end
    return v;
  endfunction

  // Apply a sign to a magnitude and saturate to the word range.
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [47:0] m);
    if (neg) begin
      if (m >= MAG_MIN) begin
        return W_MIN;
      end
      return $signed(32'(~m[31:0] + 32'd1));
    end
    if (m > MAG_MAX) begin
      return W_MAX;
    end
    return $signed(m[31:0]);
  endfunction

endpackage

>>> src/cubic_seek_trajectory.sv
// Cubic Hermite setpoint generator, Q16.16 fixed point.
// Input channel (in_valid_i/in_ready_o) takes one item: a tick carrying dt,
// a start item loading a target value and slope, or a preset of the current
// value and slope. Every item gives exactly one result item on the output
// channel (out_valid_o/out_ready_i): position, rate, phase and mode after it.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write it only while idle, as the block itself does not enforce this.
// One item is worked on at a time; in_ready_o is high only while the
// sequencer is idle. Start, preset and idle ticks go straight to the result;
// a running tick divides dt by a nonzero duration, and a restart tick adds up
// to three more divisions and further products. Every quotient comes from
// the shared restoring divider, every product from the single 32x32
// multiplier. The result sits in an output register; a stalled receiver
// holds it and the next result waits until it has been taken. Reset zeroes
// control state (mode idle) and returns the registers to their reset values.
module cubic_seek_trajectory
  import cst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [30:0]        step_time_i,
  input  logic signed [31:0] given_value_i,
  input  logic signed [31:0] given_slope_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] position_o,
  output logic signed [31:0] rate_o,
  output logic [16:0]        phase_o,
  output logic [1:0]         mode_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DONE   = 5'd1;
  localparam logic [4:0] S_DIV    = 5'd2;
  localparam logic [4:0] S_SLDIV  = 5'd3;
  localparam logic [4:0] S_SLGET  = 5'd4;
  localparam logic [4:0] S_SLCHK  = 5'd5;
  localparam logic [4:0] S_SLMUL  = 5'd6;
  localparam logic [4:0] S_SLSET  = 5'd7;
  localparam logic [4:0] S_FIT    = 5'd8;
  localparam logic [4:0] S_QMUL   = 5'd9;
  localparam logic [4:0] S_QGET   = 5'd10;
  localparam logic [4:0] S_A0DIV  = 5'd11;
  localparam logic [4:0] S_A0GET  = 5'd12;
  localparam logic [4:0] S_A1DIV  = 5'd13;
  localparam logic [4:0] S_A1GET  = 5'd14;
  localparam logic [4:0] S_ACHK   = 5'd15;
  localparam logic [4:0] S_AM0    = 5'd16;
  localparam logic [4:0] S_AM1    = 5'd17;
  localparam logic [4:0] S_AM2    = 5'd18;
  localparam logic [4:0] S_C0GET  = 5'd19;
  localparam logic [4:0] S_TSTART = 5'd20;
  localparam logic [4:0] S_TGET   = 5'd21;
  localparam logic [4:0] S_E0     = 5'd22;
  localparam logic [4:0] S_E1     = 5'd23;
  localparam logic [4:0] S_E2     = 5'd24;
  localparam logic [4:0] S_E3     = 5'd25;
  localparam logic [4:0] S_E4     = 5'd26;
  localparam logic [4:0] S_E5     = 5'd27;
  localparam logic [4:0] S_E6     = 5'd28;
  localparam logic [4:0] S_E7     = 5'd29;

  // ceil(2^34 / 6): a 32-bit magnitude times this, shifted down by 34, is floor(x / 6).
  localparam logic [31:0] RECIP_SIX = 32'hAAAA_AAAB;

  // Control and architectural state.
  logic [4:0]         state_q, state_d, ret_q, ret_d;
  logic [30:0]        dur_q, dur_d, slim_q, slim_d, alim_q, alim_d;
  logic               hold_q, hold_d;
  logic signed [31:0] cur_val_q, cur_val_d, cur_slp_q, cur_slp_d;
  logic signed [31:0] goal_val_q, goal_val_d, goal_slp_q, goal_slp_d;
  logic signed [31:0] c0_q, c0_d, c1_q, c1_d, c2_q, c2_d, c3_q, c3_d;
  logic [16:0]        t_q, t_d;
  logic [1:0]         mode_q, mode_d;
  logic               out_valid_q, out_valid_d;

  // Working registers.
  logic [30:0]        dt_q, dt_d;
  logic signed [31:0] d_q, d_d, qq_q, qq_d, a0_q, a0_d, a1_q, a1_d, two_q, two_d;
  logic signed [31:0] m0_q, m0_d, pa_q, pa_d, ps_q, ps_d, pc_q, pc_d;
  logic [47:0]        dvd_q, dvd_d;
  logic [32:0]        rem_q, rem_d;
  logic [31:0]        dsr_q, dsr_d;
  logic               dneg_q, dneg_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [63:0]        prod_q;
  logic               mneg_q;
  logic signed [31:0] pos_q, pos_d, rate_q, rate_d;
  logic [16:0]        phase_q, phase_d;
  logic [1:0]         omode_q, omode_d;

  // Shared multiplier operands and results of the shared units.
  logic [31:0]        mul_a, mul_b;
  logic               mul_neg;
  logic signed [31:0] mulres, divres;

  // Combinational helpers.
  logic signed [31:0] x_sl, x_a0, x_a1, delta, v_c0;
  logic signed [32:0] two_ext;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic [48:0]        t_sum;
  logic               hit0, hit1;

  assign mulres = sat_mag(mneg_q, prod_q[63:16]);
  assign divres = sat_mag(dneg_q, dvd_q);

  assign x_sl  = sat36((ext36(c0_q) <<< 1) + ext36(c0_q) + (ext36(c1_q) <<< 1) + ext36(c2_q));
  assign x_a0  = sat36(ext36(c1_q) <<< 1);
  assign x_a1  = sat36((ext36(c0_q) <<< 2) + (ext36(c0_q) <<< 1) + (ext36(c1_q) <<< 1));
  assign delta = sat36(ext36(goal_val_q) - ext36(cur_val_q));
  assign v_c0  = sat36(ext36(mulres) - ext36(two_q));
  assign two_ext = {mulres[31], mulres} + {32'd0, mulres[31]};
  assign rem_sh  = {rem_q[31:0], dvd_q[47]};
  assign rem_ge  = rem_sh >= {1'b0, dsr_q};
  assign t_sum   = {32'd0, t_q} + {1'b0, dvd_q};
  assign hit0    = {1'b0, abs32(a0_q)} > {2'b0, alim_q};
  assign hit1    = {1'b0, abs32(a1_q)} > {2'b0, alim_q};

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (state_q)
      S_SLMUL: begin
        mul_a = {1'b0, dur_q};
        mul_b = {1'b0, slim_q};
      end
      S_QMUL: begin
        mul_a = {1'b0, dur_q};
        mul_b = {1'b0, dur_q};
      end
      S_AM0: begin
        mul_a   = qq_q;
        mul_b   = abs32(a0_q);
        mul_neg = a0_q[31];
      end
      S_AM1: begin
        mul_a   = qq_q;
        mul_b   = abs32(a1_q);
        mul_neg = a1_q[31];
      end
      S_AM2: begin
        mul_a   = abs32(v_c0);
        mul_b   = RECIP_SIX;
        mul_neg = v_c0[31];
      end
      S_E0: begin
        mul_a   = abs32(c0_q);
        mul_b   = {15'd0, t_q};
        mul_neg = c0_q[31];
      end
      S_E2: begin
        mul_a   = abs32(pa_q);
        mul_b   = {15'd0, t_q};
        mul_neg = pa_q[31];
      end
      S_E4: begin
        mul_a   = abs32(ps_q);
        mul_b   = {15'd0, t_q};
        mul_neg = ps_q[31];
      end
      S_E6: begin
        mul_a   = abs32(pc_q);
        mul_b   = {15'd0, t_q};
        mul_neg = pc_q[31];
      end
      default: begin
        mul_neg = 1'b0;
      end
    endcase
  end

  // Sequencer and next-state logic.
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    dur_d       = dur_q;
    slim_d      = slim_q;
    alim_d      = alim_q;
    hold_d      = hold_q;
    cur_val_d   = cur_val_q;
    cur_slp_d   = cur_slp_q;
    goal_val_d  = goal_val_q;
    goal_slp_d  = goal_slp_q;
    c0_d        = c0_q;
    c1_d        = c1_q;
    c2_d        = c2_q;
    c3_d        = c3_q;
    t_d         = t_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q;
    dt_d        = dt_q;
    d_d         = d_q;
    qq_d        = qq_q;
    a0_d        = a0_q;
    a1_d        = a1_q;
    two_d       = two_q;
    m0_d        = m0_q;
    pa_d        = pa_q;
    ps_d        = ps_q;
    pc_d        = pc_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    dsr_d       = dsr_q;
    dneg_d      = dneg_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    rate_d      = rate_q;
    phase_d     = phase_q;
    omode_d     = omode_q;

    // Configuration writes.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DURATION: dur_d  = cfg_data_i;
        REG_SLOPE:    slim_d = cfg_data_i;
        REG_ACCEL:    alim_d = cfg_data_i;
        REG_HOLD:     hold_d = cfg_data_i[0];
      endcase
    end

    // The receiver takes the result item.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dt_d    = step_time_i;
          state_d = S_DONE;
          unique case (action_i)
            ACT_TICK: begin
              if (mode_q == MODE_RUN) begin
                state_d = S_TSTART;
              end else if (mode_q == MODE_RESTART) begin
                t_d = '0;
                if (!hold_q) begin
                  mode_d = MODE_RUN;
                end
                state_d = (slim_q != '0) ? S_SLDIV : S_FIT;
              end
            end
            ACT_START: begin
              goal_val_d = given_value_i;
              goal_slp_d = given_slope_i;
              mode_d     = MODE_RESTART;
            end
            ACT_PRESET: begin
              cur_val_d = given_value_i;
              cur_slp_d = given_slope_i;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          pos_d       = cur_val_q;
          rate_d      = cur_slp_q;
          phase_d     = t_q;
          omode_d     = mode_q;
          state_d     = S_IDLE;
        end
      end
      // One restoring step per cycle of the shared divider.
      S_DIV: begin
        rem_d = rem_ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
        dvd_d = {dvd_q[46:0], rem_ge};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          state_d = ret_q;
        end
      end
      // End-slope check: slope of the previous curve over the duration.
      S_SLDIV: begin
        if (dur_q == '0) begin
          d_d     = (x_sl == '0) ? '0 : (x_sl[31] ? W_MIN : W_MAX);
          state_d = S_SLCHK;
        end else begin
          dvd_d   = {abs32(x_sl), 16'd0};
          dsr_d   = {1'b0, dur_q};
          dneg_d  = x_sl[31];
          rem_d   = '0;
          cnt_d   = 6'd47;
          ret_d   = S_SLGET;
          state_d = S_DIV;
        end
      end
      S_SLGET: begin
        d_d     = divres;
        state_d = S_SLCHK;
      end
      S_SLCHK: begin
        state_d = ({1'b0, abs32(d_q)} > {2'b0, slim_q}) ? S_SLMUL : S_FIT;
      end
      S_SLMUL: begin
        state_d = S_SLSET;
      end
      S_SLSET: begin
        goal_slp_d = d_q[31] ? -mulres : mulres;
        state_d    = S_FIT;
      end
      // Hermite fit from the current point to the goal.
      S_FIT: begin
        c3_d    = cur_val_q;
        c2_d    = cur_slp_q;
        c0_d    = sat36(ext36(cur_slp_q) + ext36(goal_slp_q) - (ext36(delta) <<< 1));
        c1_d    = sat36((ext36(delta) <<< 1) + ext36(delta) - ext36(goal_slp_q)
                        - (ext36(cur_slp_q) <<< 1));
        state_d = (alim_q != '0) ? S_QMUL : S_TSTART;
      end
      S_QMUL: begin
        state_d = S_QGET;
      end
      S_QGET: begin
        qq_d    = mulres;
        state_d = S_A0DIV;
      end
      // End accelerations, each a quotient by the squared duration.
      S_A0DIV: begin
        if (qq_q == '0) begin
          a0_d    = (x_a0 == '0) ? '0 : (x_a0[31] ? W_MIN : W_MAX);
          state_d = S_A1DIV;
        end else begin
          dvd_d   = {abs32(x_a0), 16'd0};
          dsr_d   = qq_q;
          dneg_d  = x_a0[31];
          rem_d   = '0;
          cnt_d   = 6'd47;
          ret_d   = S_A0GET;
          state_d = S_DIV;
        end
      end
      S_A0GET: begin
        a0_d    = divres;
        state_d = S_A1DIV;
      end
      S_A1DIV: begin
        if (qq_q == '0) begin
          a1_d    = (x_a1 == '0) ? '0 : (x_a1[31] ? W_MIN : W_MAX);
          state_d = S_ACHK;
        end else begin
          dvd_d   = {abs32(x_a1), 16'd0};
          dsr_d   = qq_q;
          dneg_d  = x_a1[31];
          rem_d   = '0;
          cnt_d   = 6'd47;
          ret_d   = S_A1GET;
          state_d = S_DIV;
        end
      end
      S_A1GET: begin
        a1_d    = divres;
        state_d = S_ACHK;
      end
      S_ACHK: begin
        if (hit0) begin
          a0_d = a0_q[31] ? -$signed({1'b0, alim_q}) : $signed({1'b0, alim_q});
        end
        if (hit1) begin
          a1_d = a1_q[31] ? -$signed({1'b0, alim_q}) : $signed({1'b0, alim_q});
        end
        state_d = (hit0 || hit1) ? S_AM0 : S_TSTART;
      end
      S_AM0: begin
        state_d = S_AM1;
      end
      // Re-solve c1 from the clamped start acceleration, halved toward zero.
      S_AM1: begin
        two_d   = mulres;
        c1_d    = two_ext[32:1];
        state_d = S_AM2;
      end
      // c0 is the acceleration difference over six, by a reciprocal product.
      S_AM2: begin
        state_d = S_C0GET;
      end
      S_C0GET: begin
        c0_d    = mneg_q ? -$signed({2'b0, prod_q[63:34]}) : $signed({2'b0, prod_q[63:34]});
        state_d = S_TSTART;
      end
      // Advance normalised time by dt over the duration.
      S_TSTART: begin
        if (dur_q == '0) begin
          t_d     = T_ONE;
          state_d = S_E0;
        end else begin
          dvd_d   = {1'b0, dt_q, 16'd0};
          dsr_d   = {1'b0, dur_q};
          dneg_d  = 1'b0;
          rem_d   = '0;
          cnt_d   = 6'd47;
          ret_d   = S_TGET;
          state_d = S_DIV;
        end
      end
      S_TGET: begin
        if (t_sum > {32'd0, T_ONE}) begin
          t_d    = T_ONE;
          mode_d = MODE_IDLE;
        end else begin
          t_d = t_sum[16:0];
        end
        state_d = S_E0;
      end
      // Horner evaluation of value and slope at t.
      S_E0: begin
        state_d = S_E1;
      end
      S_E1: begin
        m0_d    = mulres;
        pa_d    = sat36(ext36(c1_q) + ext36(mulres));
        state_d = S_E2;
      end
      S_E2: begin
        ps_d    = sat36((ext36(m0_q) <<< 1) + ext36(m0_q) + (ext36(c1_q) <<< 1));
        state_d = S_E3;
      end
      S_E3: begin
        pc_d    = sat36(ext36(mulres) + ext36(c2_q));
        state_d = S_E4;
      end
      S_E4: begin
        state_d = S_E5;
      end
      S_E5: begin
        cur_slp_d = sat36(ext36(mulres) + ext36(c2_q));
        state_d   = S_E6;
      end
      S_E6: begin
        state_d = S_E7;
      end
      S_E7: begin
        cur_val_d = sat36(ext36(mulres) + ext36(c3_q));
        state_d   = S_DONE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      dur_q       <= DURATION_RESET;
      slim_q      <= '0;
      alim_q      <= '0;
      hold_q      <= 1'b0;
      cur_val_q   <= '0;
      cur_slp_q   <= '0;
      goal_val_q  <= '0;
      goal_slp_q  <= '0;
      c0_q        <= '0;
      c1_q        <= '0;
      c2_q        <= '0;
      c3_q        <= '0;
      t_q         <= '0;
      mode_q      <= MODE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      dur_q       <= dur_d;
      slim_q      <= slim_d;
      alim_q      <= alim_d;
      hold_q      <= hold_d;
      cur_val_q   <= cur_val_d;
      cur_slp_q   <= cur_slp_d;
      goal_val_q  <= goal_val_d;
      goal_slp_q  <= goal_slp_d;
      c0_q        <= c0_d;
      c1_q        <= c1_d;
      c2_q        <= c2_d;
      c3_q        <= c3_d;
      t_q         <= t_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers, including the multiplier product.
  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    d_q     <= d_d;
    qq_q    <= qq_d;
    a0_q    <= a0_d;
    a1_q    <= a1_d;
    two_q   <= two_d;
    m0_q    <= m0_d;
    pa_q    <= pa_d;
    ps_q    <= ps_d;
    pc_q    <= pc_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    dsr_q   <= dsr_d;
    dneg_q  <= dneg_d;
    cnt_q   <= cnt_d;
    prod_q  <= {32'd0, mul_a} * {32'd0, mul_b};
    mneg_q  <= mul_neg;
    pos_q   <= pos_d;
    rate_q  <= rate_d;
    phase_q <= phase_d;
    omode_q <= omode_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign rate_o      = rate_q;
  assign phase_o     = phase_q;
  assign mode_o      = omode_q;

  // Normalised time never passes unity.
  a_time_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_q <= T_ONE)
    else $error("normalised time beyond unity");

  // The divider never runs with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dsr_q != '0))
    else $error("divider started with zero divisor");

  // An accepted start item arms a restart.
  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ACT_START) |=> (mode_q == MODE_RESTART))
    else $error("start item did not arm a restart");

endmodule
